[rtl/core/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, constants and codes of the grid sync PLL step unit.
// ----------------------------------------------------------------------------
package gsp_pkg;

  // Parameter defaults
  localparam int SINE_TABLE_BITS_DEFAULT = 10;
  localparam int AMPLITUDE_SHIFT_DEFAULT = 8;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int AMPL_W   = 15;
  localparam int TIME_W   = 32;
  localparam int PHASE_W  = 16;
  localparam int FREQ_W   = 16;
  localparam int ERR_W    = 32;
  localparam int INT_W    = 48;
  localparam int TRACK_W  = 24;
  localparam int TRACK_FRAC = 9;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_NUM_W  = 24;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Fixed-point constants
  localparam logic [17:0] PEAK_GAIN = 18'd92682;  // sqrt(2) in Q16
  localparam logic [17:0] LOCK_GAIN = 18'd9268;   // 0.1 * sqrt(2) in Q16
  localparam logic [17:0] SIN_PI_C  = 18'd102944; // pi, Q15
  localparam logic [15:0] SIN_A_C   = 16'd42047;  // 2pi - 5, Q15
  localparam logic [17:0] SIN_B_C   = 18'd4640;   // pi - 3, Q15

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_RMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TPS     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_ANG, S_PEAK, S_XX, S_Y, S_T1, S_T2, S_SIN, S_REF,
    S_ERR, S_KI, S_AMP, S_THR, S_LOCK, S_WAIT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_ANG, OP_PEAK, OP_XX, OP_Y, OP_T1, OP_T2,
    OP_SIN, OP_REF, OP_ERR, OP_KI, OP_AMP, OP_THR, OP_LOCK, OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_pending;
    logic out_hold;
  } status_t;

endpackage

[rtl/core/gsp_div.sv]
// ----------------------------------------------------------------------------
// gsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gsp_pkg::DIV_NUM_W-1:0]  num,
  input  logic [gsp_pkg::TIME_W-1:0]     den,
  output logic                           busy,
  output logic [gsp_pkg::DIV_NUM_W-1:0]  quot
);
  import gsp_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [TIME_W:0]      rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] q_r, q_nxt;
  logic [TIME_W-1:0]    den_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [TIME_W:0]      rem_sh;

  always_comb begin
    rem_sh   = {rem_r[TIME_W-1:0], q_r[DIV_NUM_W-1]};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      cnt_nxt  = CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract, shift quotient bit in from the bottom
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

[rtl/core/gsp_ctrl.sv]
// ----------------------------------------------------------------------------
// gsp_ctrl
// Sequencer: steps the datapath through one item, one op a cycle unless held.
// ----------------------------------------------------------------------------
module gsp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  gsp_pkg::status_t status,
  output gsp_pkg::cmd_t    cmd
);
  import gsp_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_ANG;
      S_ANG:   state_nxt = S_PEAK;
      S_PEAK:  state_nxt = S_XX;
      S_XX:    state_nxt = S_Y;
      S_Y:     state_nxt = S_T1;
      S_T1:    state_nxt = S_T2;
      S_T2:    state_nxt = S_SIN;
      S_SIN:   state_nxt = S_REF;
      S_REF:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_KI;
      S_KI:    state_nxt = S_AMP;
      S_AMP:   state_nxt = S_THR;
      S_THR:   state_nxt = S_LOCK;
      S_LOCK:  state_nxt = S_WAIT;
      S_WAIT:  if (!status.div_pending) state_nxt = S_DONE;
      S_DONE:  if (!status.out_hold) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LATCH;
      end
      S_ANG:   cmd.op = OP_ANG;
      S_PEAK:  cmd.op = OP_PEAK;
      S_XX:    cmd.op = OP_XX;
      S_Y:     cmd.op = OP_Y;
      S_T1:    cmd.op = OP_T1;
      S_T2:    cmd.op = OP_T2;
      S_SIN:   cmd.op = OP_SIN;
      S_REF:   cmd.op = OP_REF;
      S_ERR:   cmd.op = OP_ERR;
      S_KI:    cmd.op = OP_KI;
      S_AMP:   cmd.op = OP_AMP;
      S_THR:   cmd.op = OP_THR;
      S_LOCK:  cmd.op = OP_LOCK;
      S_WAIT:  cmd.op = OP_NONE;
      S_DONE:  if (!status.out_hold) cmd.op = OP_LOAD;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/core/gsp_dp.sv]
// ----------------------------------------------------------------------------
// gsp_dp
// Datapath: config registers, shared multiplier, loop state, output register.
// ----------------------------------------------------------------------------
module gsp_dp #(
  parameter int SINE_TABLE_BITS = gsp_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int AMPLITUDE_SHIFT = gsp_pkg::AMPLITUDE_SHIFT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gsp_pkg::cmd_t                   cmd,
  output gsp_pkg::status_t                status,
  input  logic [gsp_pkg::IN_W-1:0]        in_tdata,
  input  logic                            cfg_valid,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gsp_pkg::OUT_W-1:0]       out_tdata
);
  import gsp_pkg::*;

  localparam int LOW_BITS = 16 - SINE_TABLE_BITS;

  // configuration
  logic [AMPL_W-1:0]        rms_r;
  logic [15:0]              step_r;
  logic signed [15:0]       kp_r, ki_r;
  logic [15:0]              tps_r;

  // item and intermediate registers
  logic signed [SAMPLE_W-1:0] sample_r, prev_r;
  logic [AMPL_W-1:0]        ampl_r;
  logic [TIME_W-1:0]        time_r, last_r;
  logic [1:0]               quad_r;
  logic [15:0]              x_r, y_r, peak_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [INT_W-1:0]  int_r;
  logic [23:0]              acc_r;
  logic [PHASE_W-1:0]       phase_r;
  logic [TRACK_W-1:0]       track_r;
  logic                     seen_r, fvalid_r, pending_r, locked_r;
  logic [FREQ_W-1:0]        freq_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;

  // combinational helpers
  logic [15:0]  angle, ang_q, x_fold;
  logic [16:0]  sin_raw;
  logic [15:0]  sin_mag;
  logic signed [15:0] sine;
  logic [15:0]  t1;
  logic [16:0]  t2;
  logic signed [17:0] ref_v;
  logic signed [ERR_W-1:0] err_v;
  logic signed [INT_W:0]   int_sum;
  logic signed [INT_W-1:0] int_sat;
  logic         crossing;
  logic [TIME_W-1:0] period;
  logic signed [TRACK_W:0] track_diff;
  logic [23:0]  acc_sum;
  logic [ERR_W-1:0] err_mag;
  logic         div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_quot;

  always_comb begin
    angle   = prod_r[15:0] + phase_r;
    ang_q   = (angle >> LOW_BITS) << LOW_BITS;
    x_fold  = {ang_q[13:0], 1'b0};
    if (ang_q[14]) x_fold = 16'd32768 - x_fold;
    t1      = SIN_A_C - {3'd0, prod_r[27:15]};
    t2      = SIN_PI_C[16:0] - prod_r[31:15];
    sin_raw = prod_r[32:16];
    sin_mag = (sin_raw > 17'd32767) ? 16'd32767 : sin_raw[15:0];
    sine    = quad_r[1] ? -$signed(sin_mag) : $signed(sin_mag);
    ref_v   = prod_r[32:15];
    err_v   = prod_r[ERR_W-1:0];
    int_sum = {int_r[INT_W-1], int_r} + {{(INT_W-ERR_W+1){err_v[ERR_W-1]}}, err_v};
    if (int_sum[INT_W] != int_sum[INT_W-1])
      int_sat = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    else
      int_sat = int_sum[INT_W-1:0];
    crossing = (prev_r[15] || (prev_r == '0)) && !sample_r[15] && (sample_r != '0);
    period   = time_r - last_r;
    div_start = (cmd.op == OP_ERR) && crossing && seen_r && (period != '0);
    track_diff = $signed({1'b0, ampl_r, {TRACK_FRAC{1'b0}}}) - $signed({1'b0, track_r});
    acc_sum  = acc_r + prod_r[23:0];
    err_mag  = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_ANG:  begin mul_a = {17'd0, time_r[15:0]};  mul_b = {2'd0, step_r}; end
      OP_PEAK: begin mul_a = {18'd0, rms_r};         mul_b = PEAK_GAIN; end
      OP_XX:   begin mul_a = {17'd0, x_r};           mul_b = {2'd0, x_r}; end
      OP_Y:    begin mul_a = {17'd0, prod_r[30:15]}; mul_b = SIN_B_C; end
      OP_T1:   begin mul_a = {17'd0, y_r};           mul_b = {2'd0, t1}; end
      OP_T2:   begin mul_a = {17'd0, x_r};           mul_b = {1'b0, t2}; end
      OP_SIN:  begin mul_a = {17'd0, peak_r};        mul_b = {{2{sine[15]}}, sine}; end
      OP_REF:  begin mul_a = {{17{sample_r[15]}}, sample_r}; mul_b = ref_v; end
      OP_ERR:  begin mul_a = {err_v[ERR_W-1], err_v}; mul_b = {{2{kp_r[15]}}, kp_r}; end
      OP_KI:   begin mul_a = {9'd0, int_r[23:0]};    mul_b = {{2{ki_r[15]}}, ki_r}; end
      OP_AMP:  begin mul_a = {18'd0, ampl_r};        mul_b = {3'd0, rms_r}; end
      OP_THR:  begin mul_a = {3'd0, prod_r[29:0]};   mul_b = LOCK_GAIN; end
      default: begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  gsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({8'd0, tps_r} << 8),
    .den   (period),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_r  <= 15'd14080;
      step_r <= 16'd32768;
      kp_r   <= 16'sd256;
      ki_r   <= 16'sd16;
      tps_r  <= 16'd20;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_RMS: rms_r  <= cfg_data[AMPL_W-1:0];
        REG_STEP:    step_r <= cfg_data;
        REG_KP:      kp_r   <= $signed(cfg_data);
        REG_KI:      ki_r   <= $signed(cfg_data);
        REG_TPS:     tps_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // loop state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      prev_r      <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      phase_r     <= '0;
      freq_r      <= '0;
      fvalid_r    <= 1'b0;
      track_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (pending_r && !div_busy) begin
        pending_r <= 1'b0;
        fvalid_r  <= 1'b1;
        freq_r    <= (div_quot[DIV_NUM_W-1:FREQ_W] != '0) ? 16'hFFFF : div_quot[FREQ_W-1:0];
      end
      unique case (cmd.op)
        OP_ERR: begin
          int_r <= int_sat;
          if (crossing) begin
            if (seen_r) begin
              if (period == '0) begin
                freq_r   <= 16'hFFFF;
                fvalid_r <= 1'b1;
              end else begin
                pending_r <= 1'b1;
              end
            end
            seen_r <= 1'b1;
            last_r <= time_r;
          end
          prev_r  <= sample_r;
          track_r <= TRACK_W'($signed({1'b0, track_r}) + (track_diff >>> AMPLITUDE_SHIFT));
        end
        // advance the phase by bits [23:8] of the PI sum
        OP_AMP:  phase_r <= phase_r + acc_sum[23:8];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        sample_r <= $signed(in_tdata[15:0]);
        ampl_r   <= in_tdata[30:16];
        time_r   <= in_tdata[62:31];
      end
      OP_PEAK: begin
        quad_r <= ang_q[15:14];
        x_r    <= x_fold;
      end
      OP_XX:   peak_r <= prod_r[31:16];
      OP_Y:    y_r    <= prod_r[30:15];
      OP_ERR:  err_r  <= err_v;
      OP_KI:   acc_r  <= prod_r[23:0];
      OP_LOCK: locked_r <= err_mag < {4'd0, prod_r[43:16]};
      OP_LOAD: begin
        out_data_r <= {7'd0, err_r, locked_r, track_r[TRACK_W-1:TRACK_FRAC], fvalid_r,
                       (fvalid_r ? freq_r : 16'd0), phase_r};
      end
      default: ;
    endcase
  end

  assign status.div_pending = pending_r;
  assign status.out_hold    = out_valid_r && !out_tready;
  assign out_tvalid         = out_valid_r;
  assign out_tdata          = out_data_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy && !pending_r)
    else $error("divider started while busy");

  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> !pending_r && !div_busy)
    else $error("result loaded before frequency settled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> !(out_valid_r && !out_tready))
    else $error("held result overwritten");

  a_fvalid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fvalid_r |=> fvalid_r)
    else $error("frequency valid dropped");

endmodule

[rtl/core/grid_sync_pll_step_unit.sv]
// ----------------------------------------------------------------------------
// grid_sync_pll_step_unit
// Grid sync PLL step: multiplier phase detector, PI loop, frequency and
// amplitude tracking, one result per grid sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one grid sample per transfer (sample, measured RMS, sample time).
//   out_* : one result per input item, held in an output register until taken.
//   cfg_* : register writes (index, data); always ready, write only while idle.
// Timing: the shared 33x18 multiplier runs 12 steps in sequence (ANG, PEAK,
// XX, Y, T1, T2, SIN, REF, ERR, KI, AMP, THR); the sequencer then passes LOCK,
// WAIT and DONE, loads the result into the output register and returns to
// idle to take the next item. On a rising zero crossing with a prior crossing
// and a nonzero period, the sequencer holds in WAIT for the period divider.
// The next item is taken as soon as the previous result is in the output
// register, even while the receiver stalls; the block then waits at the end of
// that next item until the output register frees up.
// Reset (rst_n low, synchronous) clears the loop state, marks the frequency
// invalid and loads the default register values.
// ----------------------------------------------------------------------------
module grid_sync_pll_step_unit #(
  parameter int SINE_TABLE_BITS = gsp_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int AMPLITUDE_SHIFT = gsp_pkg::AMPLITUDE_SHIFT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] grid_sample, [30:16] grid_amplitude_rms, [62:31] sample_time
  input  logic [gsp_pkg::IN_W-1:0]        in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] loop_phase, [31:16] estimated_frequency, [32] frequency_valid,
  // [47:33] amplitude_estimate, [48] locked, [80:49] phase_error
  output logic [gsp_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  gsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gsp_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .AMPLITUDE_SHIFT (AMPLITUDE_SHIFT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
